### hdl/nnt_pkg.sv
package nnt_pkg;

    // Matrix geometry
    localparam int MAX_CITIES  = 64;
    localparam int CITY_BITS   = 6;
    localparam int COUNT_BITS  = 7;
    localparam int ADDR_BITS   = 2 * CITY_BITS;
    localparam int STORE_DEPTH = MAX_CITIES * MAX_CITIES;

    // Weights and tour length
    localparam int WEIGHT_BITS = 16;
    localparam int INPUT_WEIGHT_BITS = 16;
    localparam int LENGTH_BITS = 22;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    // City count register
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_CITIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MIN   = COUNT_BITS'(2);

    // Request codes
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_RUN   = 1'b1
    } t_req;

endpackage

### hdl/nnt_ram.sv
module nnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nearest_neighbor_tour.sv
// Greedy nearest-neighbor tour builder over a 64 x 64 directed weight matrix held in one
// block RAM. A write item (req_type 0) stores one weight. A run item
// (req_type 1) starts at city 0 and emits one transfer per tour position, city 0 first;
// at each step every city below city_count is scanned and the unvisited one with the
// strictly smallest weight from the current city wins, so ties go to the lower index.
// The last transfer carries the closed tour length (saturating at 4194303) and
// last_result. The scan reads one matrix entry per cycle through the single RAM read
// port; the input is stalled for the whole run. city_count is clamped to 2..64 at run
// start. Reading a matrix entry that was never written returns an undefined weight.
module nearest_neighbor_tour (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [nnt_pkg::COUNT_BITS-1:0]     i_cfg_city_count,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_from_city,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_to_city,
    input  logic [nnt_pkg::INPUT_WEIGHT_BITS-1:0] i_edge_weight,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [nnt_pkg::CITY_BITS-1:0]      o_tour_position,
    output logic [nnt_pkg::CITY_BITS-1:0]      o_city_id,
    output logic [nnt_pkg::LENGTH_BITS-1:0]    o_tour_length,
    output logic                               o_last_result
);

    import nnt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_CLOSE,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [COUNT_BITS-1:0]   r_city_count;
    logic [COUNT_BITS-1:0]   r_n;
    logic [COUNT_BITS-1:0]   r_j;
    logic [CITY_BITS-1:0]    r_cur;
    logic [CITY_BITS-1:0]    r_pos;
    logic [MAX_CITIES-1:0]   r_visited;
    logic [LENGTH_BITS-1:0]  r_sum;
    logic                    r_last;
    logic                    r_have;
    logic [CITY_BITS-1:0]    r_best_idx;
    logic [WEIGHT_BITS-1:0]  r_best_w;
    logic                    r_rd_vld;
    logic [CITY_BITS-1:0]    r_rd_j;

    logic                    r_o_valid;
    logic [CITY_BITS-1:0]    r_o_pos;
    logic [CITY_BITS-1:0]    r_o_city;
    logic [LENGTH_BITS-1:0]  r_o_length;
    logic                    r_o_last;

    logic                    in_xfer;
    logic                    out_free;
    logic                    ram_we;
    logic [ADDR_BITS-1:0]    ram_waddr;
    logic [ADDR_BITS-1:0]    ram_raddr;
    logic [WEIGHT_BITS-1:0]  ram_rdata;
    logic [COUNT_BITS-1:0]   n_n;
    logic                    cand_take;
    logic [LENGTH_BITS-1:0]  sum_add_best;
    logic [LENGTH_BITS-1:0]  sum_add_rd;
    logic                    pick_last;

    // Saturating add into the tour length
    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] sum,
        input logic [WEIGHT_BITS-1:0] w
    );
        logic [LENGTH_BITS:0] t;
        t = {1'b0, sum} + (LENGTH_BITS+1)'(w);
        return t[LENGTH_BITS] ? LENGTH_MAX : t[LENGTH_BITS-1:0];
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;

    // Weight store
    assign ram_we    = in_xfer && (t_req'(i_req_type) == REQ_WRITE);
    assign ram_waddr = {i_from_city, i_to_city};
    assign ram_raddr = (r_state == S_SCAN) ? {r_cur, r_j[CITY_BITS-1:0]}
                                           : {r_best_idx, CITY_BITS'(0)};

    nnt_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_edge_weight[WEIGHT_BITS-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Clamp the city count at run start
    always_comb begin
        priority if (r_city_count < COUNT_MIN) begin
            n_n = COUNT_MIN;
        end else if (r_city_count > COUNT_RESET) begin
            n_n = COUNT_RESET;
        end else begin
            n_n = r_city_count;
        end
    end

    // Compare the returned weight against the best so far
    assign cand_take = r_rd_vld && !r_visited[r_rd_j] && (!r_have || ram_rdata < r_best_w);

    assign sum_add_best = sat_add(r_sum, r_best_w);
    assign sum_add_rd   = sat_add(r_sum, ram_rdata);
    assign pick_last    = ({1'b0, r_pos} + COUNT_BITS'(1)) == (r_n - COUNT_BITS'(1));

    // Sequencer, scan datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_city_count <= COUNT_RESET;
            r_o_valid    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_have       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_city_count <= i_cfg_city_count;
            end

            // Drop the output once it has been taken, unless a new one loads now
            if (r_o_valid && !i_out_stall && r_state != S_START && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end

            // Scan pipeline: the read issued in the previous cycle returns now
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_j   <= r_j[CITY_BITS-1:0];
            if (cand_take) begin
                r_have     <= 1'b1;
                r_best_idx <= r_rd_j;
                r_best_w   <= ram_rdata;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && t_req'(i_req_type) == REQ_RUN) begin
                        r_n       <= n_n;
                        r_visited <= MAX_CITIES'(1);
                        r_cur     <= '0;
                        r_pos     <= '0;
                        r_sum     <= '0;
                        r_last    <= 1'b0;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    // Emit the start city, then begin the first scan
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_pos    <= '0;
                        r_o_city   <= '0;
                        r_o_length <= '0;
                        r_o_last   <= 1'b0;
                        r_j        <= '0;
                        r_have     <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_j <= r_j + COUNT_BITS'(1);
                    if (r_j == r_n - COUNT_BITS'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    // Move to the chosen city
                    r_visited <= r_visited | (MAX_CITIES'(1) << r_best_idx);
                    r_cur     <= r_best_idx;
                    r_sum     <= sum_add_best;
                    r_pos     <= r_pos + CITY_BITS'(1);
                    r_last    <= pick_last;
                    r_state   <= pick_last ? S_CLOSE : S_EMIT;
                end
                S_CLOSE: begin
                    // Closing edge back to city 0
                    r_sum   <= sum_add_rd;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_pos    <= r_pos;
                        r_o_city   <= r_cur;
                        r_o_length <= r_last ? r_sum : '0;
                        r_o_last   <= r_last;
                        r_j        <= '0;
                        r_have     <= 1'b0;
                        r_state    <= r_last ? S_IDLE : S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_tour_position = r_o_pos;
    assign o_city_id       = r_o_city;
    assign o_tour_length   = r_o_length;
    assign o_last_result   = r_o_last;

    // The last transfer sits at the final tour position
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> ({1'b0, o_tour_position} == r_n - COUNT_BITS'(1)))
        else $error("last transfer not at final tour position");

    // Tour length shows only on the last transfer
    a_length_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> (o_tour_length == '0))
        else $error("tour length on a non-final transfer");

    // The current city is always marked visited while scanning
    a_cur_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_visited[r_cur])
        else $error("current city not visited during scan");

    // One visited city per emitted position
    a_visit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_visited) == int'(r_pos) + 1))
        else $error("visited count out of step with tour position");

endmodule

### dv/nnt_tour_checker.sv
module nnt_tour_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nnt_pkg::COUNT_BITS-1:0]     i_cfg_city_count,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  nnt_pkg::t_req                      i_req_type,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_from_city,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_to_city,
    input  logic [nnt_pkg::INPUT_WEIGHT_BITS-1:0] i_edge_weight,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_tour_position,
    input  logic [nnt_pkg::CITY_BITS-1:0]      i_city_id,
    input  logic [nnt_pkg::LENGTH_BITS-1:0]    i_tour_length,
    input  logic                               i_last_result,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import nnt_pkg::*;

    // One expected output transfer: a single stop of the tour
    typedef struct packed {
        logic [CITY_BITS-1:0]   position;
        logic [CITY_BITS-1:0]   city;
        logic [LENGTH_BITS-1:0] length;
        logic                   is_last;
    } t_stop;

    logic [WEIGHT_BITS-1:0] weight_mem [MAX_CITIES][MAX_CITIES];
    logic [COUNT_BITS-1:0]  count_reg;
    t_stop                  tour_stops [$];

    // Add one edge to the running tour length, pinned at the field maximum
    function automatic logic [LENGTH_BITS-1:0] add_capped(
        input logic [LENGTH_BITS-1:0] sum,
        input logic [WEIGHT_BITS-1:0] w
    );
        logic [LENGTH_BITS:0] wide;
        wide = {1'b0, sum} + (LENGTH_BITS+1)'(w);
        return wide[LENGTH_BITS] ? LENGTH_MAX : wide[LENGTH_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [MAX_CITIES-1:0]  seen;
        int                     n;
        int                     here;
        int                     pick;
        logic [WEIGHT_BITS-1:0] best;
        logic [LENGTH_BITS-1:0] total;
        bit                     have;
        t_stop                  stop;
        t_stop                  want;

        if (!i_rst_n) begin
            count_reg = COUNT_RESET;
            tour_stops.delete();
        end else begin
            // Compare an output transfer against the oldest predicted stop
            if (i_out_valid && !i_out_stall) begin
                if (tour_stops.size() == 0) begin
                    $error("tour stop with nothing expected: position %0d city %0d",
                           i_tour_position, i_city_id);
                    o_fail_count++;
                end else begin
                    want = tour_stops.pop_front();
                    if (i_tour_position !== want.position) begin
                        $error("tour_position: expected %0d, got %0d",
                               want.position, i_tour_position);
                        o_fail_count++;
                    end
                    if (i_city_id !== want.city) begin
                        $error("city_id: expected %0d, got %0d", want.city, i_city_id);
                        o_fail_count++;
                    end
                    if (i_tour_length !== want.length) begin
                        $error("tour_length: expected %0d, got %0d",
                               want.length, i_tour_length);
                        o_fail_count++;
                    end
                    if (i_last_result !== want.is_last) begin
                        $error("last_result: expected %0d, got %0d",
                               want.is_last, i_last_result);
                        o_fail_count++;
                    end
                end
            end

            // Store a weight, or build the greedy tour for a run request
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_WRITE) begin
                    weight_mem[i_from_city][i_to_city] = WEIGHT_BITS'(i_edge_weight);
                end else begin
                    n = count_reg;
                    if (n < COUNT_MIN)
                        n = COUNT_MIN;
                    if (n > MAX_CITIES)
                        n = MAX_CITIES;
                    seen  = '0;
                    seen[0] = 1'b1;
                    here  = 0;
                    total = '0;
                    stop  = '0;
                    tour_stops.push_back(stop);
                    for (int p = 1; p < n; p++) begin
                        // Strict less-than keeps the lowest index on a tie
                        have = 1'b0;
                        pick = 0;
                        best = '0;
                        for (int j = 0; j < n; j++) begin
                            if (!seen[j] && (!have || weight_mem[here][j] < best)) begin
                                have = 1'b1;
                                pick = j;
                                best = weight_mem[here][j];
                            end
                        end
                        seen[pick]    = 1'b1;
                        here          = pick;
                        total         = add_capped(total, best);
                        stop.position = CITY_BITS'(p);
                        stop.city     = CITY_BITS'(pick);
                        stop.length   = '0;
                        stop.is_last  = 1'b0;
                        // Close the loop back to city 0 on the final stop
                        if (p == n - 1) begin
                            total        = add_capped(total, weight_mem[here][0]);
                            stop.length  = total;
                            stop.is_last = 1'b1;
                        end
                        tour_stops.push_back(stop);
                    end
                end
            end

            // Track the city count; a run at this edge used the old value
            if (i_cfg_we)
                count_reg = i_cfg_city_count;
        end
        o_pending = tour_stops.size();
    end

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nnt_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int LOAD_CITIES  = 8;
    localparam int SETTLE       = 8;
    localparam int DRAIN_LIMIT  = 50000;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         cfg_we         = 1'b0;
    logic [COUNT_BITS-1:0]        cfg_city_count = '0;
    logic                         in_valid       = 1'b0;
    logic                         in_stall;
    t_req                         req_type       = REQ_WRITE;
    logic [CITY_BITS-1:0]         from_city      = '0;
    logic [CITY_BITS-1:0]         to_city        = '0;
    logic [INPUT_WEIGHT_BITS-1:0] edge_weight    = '0;
    logic                         out_valid;
    logic                         out_stall      = 1'b0;
    logic [CITY_BITS-1:0]         tour_position;
    logic [CITY_BITS-1:0]         city_id;
    logic [LENGTH_BITS-1:0]       tour_length;
    logic                         last_result;
    int                           fail_count;
    int                           pending;

    bit calm          = 1'b0;
    int write_count   = 0;
    int tour_count    = 0;
    int setting_count = 0;

    nearest_neighbor_tour dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_city_count (cfg_city_count),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_from_city      (from_city),
        .i_to_city        (to_city),
        .i_edge_weight    (edge_weight),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_tour_position  (tour_position),
        .o_city_id        (city_id),
        .o_tour_length    (tour_length),
        .o_last_result    (last_result)
    );

    nnt_tour_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_city_count (cfg_city_count),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_from_city      (from_city),
        .i_to_city        (to_city),
        .i_edge_weight    (edge_weight),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_tour_position  (tour_position),
        .i_city_id        (city_id),
        .i_tour_length    (tour_length),
        .i_last_result    (last_result),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bias toward tiny values so ties show up, plus both extremes
    function automatic int pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 3);
        if (r < 45)
            return 0;
        if (r < 55)
            return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // Present one request and hold it until the transfer happens
    task automatic send_item(input t_req kind, input int row, input int col, input int w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        from_city   <= CITY_BITS'(row);
        to_city     <= CITY_BITS'(col);
        edge_weight <= INPUT_WEIGHT_BITS'(w);
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (kind == REQ_RUN)
            tour_count++;
        else
            write_count++;
    endtask

    // Run request with junk in the unused fields
    task automatic send_run();
        send_item(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 16'hFFFF));
    endtask

    // Drain all tours, let the block settle, then change the city count
    task automatic set_count(input logic [COUNT_BITS-1:0] raw);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we         <= 1'b1;
        cfg_city_count <= raw;
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Output back-pressure: free stretches broken by stalls
    initial begin : out_stall_gen
        int hold;
        forever begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(negedge clk);
            else
                repeat ($urandom_range(1, 12)) @(negedge clk);
            hold = calm ? 0 : pick_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int r;
        int n;
        int waited;
        int random_items;

        random_items = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load the corner of the matrix that the tours use; the diagonal is never used
        calm = 1'b1;
        for (int f = 0; f < LOAD_CITIES; f++)
            for (int t = 0; t < LOAD_CITIES; t++)
                if (f != t)
                    send_item(REQ_WRITE, f, t, pick_weight());
        calm = 1'b0;

        // Two cities, heaviest and lightest edges; diagonal write is never used
        set_count(7'd2);
        send_item(REQ_WRITE, 0, 1, 16'hFFFF);
        send_item(REQ_WRITE, 1, 0, 0);
        send_run();
        send_item(REQ_WRITE, 0, 0, 16'hA5A5);
        send_run();

        // Counts below the minimum clamp up to two cities
        set_count(7'd0);
        send_run();
        set_count(7'd1);
        send_item(REQ_WRITE, 1, 0, 16'hFFFF);
        send_run();

        // All-equal weights: every step ties and the lower index wins
        set_count(7'd4);
        for (int f = 0; f < 4; f++)
            for (int t = 0; t < 4; t++)
                if (f != t)
                    send_item(REQ_WRITE, f, t, 5);
        send_run();
        send_item(REQ_WRITE, 0, 3, 0);
        send_run();

        // Random phases of small tours with reshuffled weights
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                n = 2;
            else
                n = $urandom_range(3, LOAD_CITIES);
            set_count(COUNT_BITS'(n));
            calm = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(10, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_run();
                else if (r < 90)
                    send_item(REQ_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              pick_weight());
                else
                    send_item(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                              pick_weight());
                random_items++;
            end
            calm = 1'b0;
        end

        // Drain, then give the verdict
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        $display("covered %0d matrix writes and %0d tours over %0d city-count settings",
                 write_count, tour_count, setting_count);
        $display("tour sizes ran from 2 to %0d cities, with random stalls on both channels",
                 LOAD_CITIES);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            if (pending != 0)
                $error("%0d tour stops never arrived", pending);
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin : watchdog
        #10_000_000;
        $error("timeout waiting for the block");
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/nnt_pkg.sv
hdl/nnt_ram.sv
hdl/nearest_neighbor_tour.sv
dv/nnt_tour_checker.sv
dv/tb.sv
